FILE: rtl/core/agl_pkg.sv
// Shared constants and types of the Annex-B newest-GOP locator.
package agl_pkg;

  localparam int OFFSET_BITS_DEF = 40;
  localparam int OUT_W           = 40;
  localparam int Q_DEPTH         = 4;

  localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
  localparam logic [4:0] NAL_SPS       = 5'd7;
  localparam logic [4:0] NAL_PPS       = 5'd8;
  localparam logic [4:0] NAL_IDR       = 5'd5;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;

  typedef struct packed {
    logic hdr_sps;
    logic hdr_pps;
    logic hdr_idr;
    logic end_sps;
    logic end_pps;
    logic last;
  } agl_evt_t;

  localparam int EVT_W = $bits(agl_evt_t);

endpackage

FILE: rtl/core/agl_front.sv
// Start code scanner that classifies NAL headers and emits stream events.
module agl_front #(
  parameter int OFFSET_BITS = agl_pkg::OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_last_byte,
  output logic                   in_stall,
  input  logic                   q_full,
  output logic                   q_push,
  output agl_pkg::agl_evt_t      q_evt,
  output logic [OFFSET_BITS-1:0] q_code
);
  import agl_pkg::*;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [1:0]             zrun_r, zrun_nxt;
  logic                   hdr_exp_r, hdr_exp_nxt;
  logic [OFFSET_BITS-1:0] pend_r, pend_nxt;
  logic [4:0]             kind_r, kind_nxt;

  logic                   accept;
  logic [4:0]             kind_now;
  logic                   start_found;
  logic [OFFSET_BITS-1:0] code_new;
  agl_evt_t               evt;

  assign accept      = in_valid && !q_full;
  assign in_stall    = q_full;
  assign kind_now    = hdr_exp_r ? (in_data_byte[4:0] & NAL_TYPE_MASK) : kind_r;
  assign start_found = (in_data_byte == BYTE_ONE) && (zrun_r >= 2'd2);
  assign code_new    = pos_r - {{(OFFSET_BITS-2){1'b0}}, zrun_r};

  always_comb begin
    evt.hdr_sps = hdr_exp_r && (kind_now == NAL_SPS);
    evt.hdr_pps = hdr_exp_r && (kind_now == NAL_PPS);
    evt.hdr_idr = hdr_exp_r && (kind_now == NAL_IDR);
    evt.end_sps = start_found && (kind_now == NAL_SPS);
    evt.end_pps = start_found && (kind_now == NAL_PPS);
    evt.last    = in_last_byte;
  end

  assign q_evt  = evt;
  assign q_code = hdr_exp_r ? pend_r : code_new;
  assign q_push = accept && (evt.hdr_sps || evt.hdr_pps || evt.hdr_idr ||
                             evt.end_sps || evt.end_pps || evt.last);

  always_comb begin
    pos_nxt     = pos_r;
    zrun_nxt    = zrun_r;
    hdr_exp_nxt = hdr_exp_r;
    pend_nxt    = pend_r;
    kind_nxt    = kind_r;
    if (accept) begin
      kind_nxt    = kind_now;
      hdr_exp_nxt = start_found;
      if (in_data_byte == BYTE_ZERO) begin
        if (zrun_r != 2'd3) begin
          zrun_nxt = zrun_r + 2'd1;
        end
      end else begin
        zrun_nxt = 2'd0;
      end
      if (start_found) begin
        pend_nxt = code_new;
      end
      if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
      end
      if (in_last_byte) begin
        pos_nxt     = '0;
        zrun_nxt    = 2'd0;
        hdr_exp_nxt = 1'b0;
        pend_nxt    = '0;
        kind_nxt    = 5'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      zrun_r    <= 2'd0;
      hdr_exp_r <= 1'b0;
      pend_r    <= '0;
      kind_r    <= 5'd0;
    end else begin
      pos_r     <= pos_nxt;
      zrun_r    <= zrun_nxt;
      hdr_exp_r <= hdr_exp_nxt;
      pend_r    <= pend_nxt;
      kind_r    <= kind_nxt;
    end
  end

endmodule

FILE: rtl/core/agl_fifo.sv
// Short event queue between the scanner and the group tracker.
module agl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = agl_pkg::Q_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             not_empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_FULL);
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + {{(PTR_W-1){1'b0}}, 1'b1};
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + {{(PTR_W-1){1'b0}}, 1'b1};
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + {{(CNT_W-1){1'b0}}, 1'b1};
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - {{(CNT_W-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/agl_back.sv
// Group tracker that keeps the newest SPS, PPS and qualifying IDR offsets.
module agl_back #(
  parameter int OFFSET_BITS = agl_pkg::OFFSET_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  agl_pkg::agl_evt_t          q_evt,
  input  logic [OFFSET_BITS-1:0]     q_code,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_found,
  output logic [agl_pkg::OUT_W-1:0]  out_sps_start,
  output logic [agl_pkg::OUT_W-1:0]  out_sps_end,
  output logic [agl_pkg::OUT_W-1:0]  out_pps_start,
  output logic [agl_pkg::OUT_W-1:0]  out_pps_end,
  output logic [agl_pkg::OUT_W-1:0]  out_idr_start
);
  import agl_pkg::*;

  logic                   sps_v_r, sps_v_nxt;
  logic                   pps_v_r, pps_v_nxt;
  logic [OFFSET_BITS-1:0] sps_st_r, sps_st_nxt;
  logic [OFFSET_BITS-1:0] sps_end_r, sps_end_nxt;
  logic [OFFSET_BITS-1:0] pps_st_r, pps_st_nxt;
  logic [OFFSET_BITS-1:0] pps_end_r, pps_end_nxt;

  logic                   c_found_r, c_found_nxt;
  logic [OFFSET_BITS-1:0] c_sps_st_r, c_sps_st_nxt;
  logic [OFFSET_BITS-1:0] c_sps_end_r, c_sps_end_nxt;
  logic [OFFSET_BITS-1:0] c_pps_st_r, c_pps_st_nxt;
  logic [OFFSET_BITS-1:0] c_pps_end_r, c_pps_end_nxt;
  logic [OFFSET_BITS-1:0] c_idr_r, c_idr_nxt;

  logic                   o_valid_r, o_valid_nxt;
  logic                   o_found_r, o_found_nxt;
  logic [OUT_W-1:0]       o_sps_st_r, o_sps_st_nxt;
  logic [OUT_W-1:0]       o_sps_end_r, o_sps_end_nxt;
  logic [OUT_W-1:0]       o_pps_st_r, o_pps_st_nxt;
  logic [OUT_W-1:0]       o_pps_end_r, o_pps_end_nxt;
  logic [OUT_W-1:0]       o_idr_r, o_idr_nxt;

  assign q_pop = q_valid && (!q_evt.last || !o_valid_r || !out_stall);

  always_comb begin
    sps_v_nxt     = sps_v_r;
    pps_v_nxt     = pps_v_r;
    sps_st_nxt    = sps_st_r;
    sps_end_nxt   = sps_end_r;
    pps_st_nxt    = pps_st_r;
    pps_end_nxt   = pps_end_r;
    c_found_nxt   = c_found_r;
    c_sps_st_nxt  = c_sps_st_r;
    c_sps_end_nxt = c_sps_end_r;
    c_pps_st_nxt  = c_pps_st_r;
    c_pps_end_nxt = c_pps_end_r;
    c_idr_nxt     = c_idr_r;
    o_valid_nxt   = o_valid_r && out_stall;
    o_found_nxt   = o_found_r;
    o_sps_st_nxt  = o_sps_st_r;
    o_sps_end_nxt = o_sps_end_r;
    o_pps_st_nxt  = o_pps_st_r;
    o_pps_end_nxt = o_pps_end_r;
    o_idr_nxt     = o_idr_r;
    if (q_pop) begin
      if (q_evt.hdr_sps) begin
        sps_st_nxt = q_code;
        sps_v_nxt  = 1'b1;
      end
      if (q_evt.hdr_pps) begin
        pps_st_nxt = q_code;
        pps_v_nxt  = 1'b1;
      end
      if (q_evt.hdr_idr && sps_v_r && pps_v_r) begin
        c_found_nxt   = 1'b1;
        c_sps_st_nxt  = sps_st_r;
        c_sps_end_nxt = sps_end_r;
        c_pps_st_nxt  = pps_st_r;
        c_pps_end_nxt = pps_end_r;
        c_idr_nxt     = q_code;
      end
      if (q_evt.end_sps) begin
        sps_end_nxt = q_code;
      end
      if (q_evt.end_pps) begin
        pps_end_nxt = q_code;
      end
      if (q_evt.last) begin
        o_valid_nxt   = 1'b1;
        o_found_nxt   = c_found_nxt;
        o_sps_st_nxt  = OUT_W'({{OUT_W{1'b0}}, c_sps_st_nxt});
        o_sps_end_nxt = OUT_W'({{OUT_W{1'b0}}, c_sps_end_nxt});
        o_pps_st_nxt  = OUT_W'({{OUT_W{1'b0}}, c_pps_st_nxt});
        o_pps_end_nxt = OUT_W'({{OUT_W{1'b0}}, c_pps_end_nxt});
        o_idr_nxt     = OUT_W'({{OUT_W{1'b0}}, c_idr_nxt});
        sps_v_nxt     = 1'b0;
        pps_v_nxt     = 1'b0;
        sps_st_nxt    = '0;
        sps_end_nxt   = '0;
        pps_st_nxt    = '0;
        pps_end_nxt   = '0;
        c_found_nxt   = 1'b0;
        c_sps_st_nxt  = '0;
        c_sps_end_nxt = '0;
        c_pps_st_nxt  = '0;
        c_pps_end_nxt = '0;
        c_idr_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sps_v_r     <= 1'b0;
      pps_v_r     <= 1'b0;
      sps_st_r    <= '0;
      sps_end_r   <= '0;
      pps_st_r    <= '0;
      pps_end_r   <= '0;
      c_found_r   <= 1'b0;
      c_sps_st_r  <= '0;
      c_sps_end_r <= '0;
      c_pps_st_r  <= '0;
      c_pps_end_r <= '0;
      c_idr_r     <= '0;
      o_valid_r   <= 1'b0;
    end else begin
      sps_v_r     <= sps_v_nxt;
      pps_v_r     <= pps_v_nxt;
      sps_st_r    <= sps_st_nxt;
      sps_end_r   <= sps_end_nxt;
      pps_st_r    <= pps_st_nxt;
      pps_end_r   <= pps_end_nxt;
      c_found_r   <= c_found_nxt;
      c_sps_st_r  <= c_sps_st_nxt;
      c_sps_end_r <= c_sps_end_nxt;
      c_pps_st_r  <= c_pps_st_nxt;
      c_pps_end_r <= c_pps_end_nxt;
      c_idr_r     <= c_idr_nxt;
      o_valid_r   <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_found_r   <= o_found_nxt;
    o_sps_st_r  <= o_sps_st_nxt;
    o_sps_end_r <= o_sps_end_nxt;
    o_pps_st_r  <= o_pps_st_nxt;
    o_pps_end_r <= o_pps_end_nxt;
    o_idr_r     <= o_idr_nxt;
  end

  assign out_valid     = o_valid_r;
  assign out_found     = o_found_r;
  assign out_sps_start = o_sps_st_r;
  assign out_sps_end   = o_sps_end_r;
  assign out_pps_start = o_pps_st_r;
  assign out_pps_end   = o_pps_end_r;
  assign out_idr_start = o_idr_r;

endmodule

FILE: rtl/core/annexb_newest_gop_locator_unit.sv
// Top level of the Annex-B newest-GOP locator.
//
// The input channel takes one byte of an H.264 Annex-B stream per transaction
// together with a flag that marks the final byte of the stream. The result
// channel delivers one transaction per stream: a found flag and the start and
// end offsets of the newest SPS and PPS that precede the newest IDR, plus the
// start offset of that IDR. Offsets are byte positions that saturate.
// The block takes one byte per cycle unless the queue is full. A scanner finds start codes and
// classifies NAL headers, then hands the events that matter through a
// four-entry queue to a group tracker, which keeps the candidate offsets.
// The result is registered on the output register once the event of the final
// byte leaves the queue. While the receiver stalls, the result holds and the scanner
// keeps taking bytes; it stalls only once the next stream end waits at the
// head of the queue with three more events queued behind it.
// A synchronous reset clears the position, the scanner, the queue and the
// tracked group; the state returns to the same values after every result.
module annexb_newest_gop_locator_unit #(
  parameter int OFFSET_BITS = agl_pkg::OFFSET_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_last_byte,
  output logic                      in_stall,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_found,
  output logic [agl_pkg::OUT_W-1:0] out_sps_start,
  output logic [agl_pkg::OUT_W-1:0] out_sps_end,
  output logic [agl_pkg::OUT_W-1:0] out_pps_start,
  output logic [agl_pkg::OUT_W-1:0] out_pps_end,
  output logic [agl_pkg::OUT_W-1:0] out_idr_start
);
  import agl_pkg::*;

  localparam int Q_W = EVT_W + OFFSET_BITS;

  logic                   q_push, q_pop, q_full, q_not_empty;
  agl_evt_t               f_evt, b_evt;
  logic [OFFSET_BITS-1:0] f_code, b_code;
  logic [Q_W-1:0]         q_rd;

  agl_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .in_stall    (in_stall),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_evt       (f_evt),
    .q_code      (f_code)
  );

  agl_fifo #(
    .WIDTH(Q_W),
    .DEPTH(Q_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_data  ({f_evt, f_code}),
    .pop      (q_pop),
    .rd_data  (q_rd),
    .full     (q_full),
    .not_empty(q_not_empty)
  );

  assign b_evt  = agl_evt_t'(q_rd[Q_W-1:OFFSET_BITS]);
  assign b_code = q_rd[OFFSET_BITS-1:0];

  agl_back #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_not_empty),
    .q_evt        (b_evt),
    .q_code       (b_code),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_found    (out_found),
    .out_sps_start(out_sps_start),
    .out_sps_end  (out_sps_end),
    .out_pps_start(out_pps_start),
    .out_pps_end  (out_pps_end),
    .out_idr_start(out_idr_start)
  );

endmodule

FILE: rtl/core/agl_checker.sv
// Port-level checks of the newest-GOP locator and their binding to the top level.
module agl_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      out_found,
  input logic [agl_pkg::OUT_W-1:0] out_sps_start,
  input logic [agl_pkg::OUT_W-1:0] out_sps_end,
  input logic [agl_pkg::OUT_W-1:0] out_pps_start,
  input logic [agl_pkg::OUT_W-1:0] out_pps_end,
  input logic [agl_pkg::OUT_W-1:0] out_idr_start
);

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result transaction present right after reset.");

  a_empty_group_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |->
      (out_sps_start == '0 && out_sps_end == '0 && out_pps_start == '0 &&
       out_pps_end == '0 && out_idr_start == '0))
    else $error("Result without a group carries nonzero offsets.");

  a_idr_after_params: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |->
      (out_idr_start >= out_sps_start && out_idr_start >= out_pps_start))
    else $error("IDR offset precedes its parameter sets.");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_found) &&
      $stable(out_idr_start) && $stable(out_sps_start)))
    else $error("Stalled result transaction changed.");

endmodule

bind annexb_newest_gop_locator_unit agl_checker u_agl_checker (.*);

FILE: tb/tb_annexb_newest_gop_locator_unit.sv
// Self-checking testbench for the Annex-B newest-GOP locator with a stream-level predictor.
module tb_annexb_newest_gop_locator_unit;
  import agl_pkg::*;

  localparam int POS_BITS = 16;
  localparam logic [POS_BITS-1:0] POS_LIMIT = '1;
  localparam logic [4:0] NAL_SLICE = 5'd1;
  localparam int DIR_N = 24;
  localparam int RANDOM_BYTES = 1150;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    bit found;
    logic [OUT_W-1:0] sps_start, sps_end, pps_start, pps_end, idr_start;
  } gop_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic [7:0] in_data_byte;
  logic in_last_byte;
  logic in_stall;
  logic out_valid;
  logic out_stall;
  logic out_found;
  logic [OUT_W-1:0] out_sps_start, out_sps_end, out_pps_start, out_pps_end, out_idr_start;

  // Predictor state.
  logic [POS_BITS-1:0] scan_pos, code_pos, sps_beg, sps_fin, pps_beg, pps_fin;
  logic [1:0] zero_count;
  logic [4:0] nal_kind;
  bit header_next, sps_seen, pps_seen;
  gop_t tracked_gop;
  gop_t gop_q[$];

  gop_t blank_gop;
  gop_t dir_gops[3];
  logic [8:0] dir_rows[DIR_N];
  string field_name[6];
  int errors = 0;
  int sent_bytes = 0;
  int burst_left = 0;
  bit idle_en = 1'b0;
  bit hold_req = 1'b0;

  always #5 clk = ~clk;

  annexb_newest_gop_locator_unit #(.OFFSET_BITS(POS_BITS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_found(out_found),
    .out_sps_start(out_sps_start),
    .out_sps_end(out_sps_end),
    .out_pps_start(out_pps_start),
    .out_pps_end(out_pps_end),
    .out_idr_start(out_idr_start)
  );

  function automatic void clear_scanner();
    scan_pos = '0;
    code_pos = '0;
    zero_count = '0;
    header_next = 1'b0;
    nal_kind = '0;
    sps_seen = 1'b0;
    pps_seen = 1'b0;
    sps_beg = '0;
    sps_fin = '0;
    pps_beg = '0;
    pps_fin = '0;
    tracked_gop = '{default: '0};
  endfunction

  function automatic bit scan_byte(input logic [7:0] b, input bit last, output gop_t res);
    logic [4:0] k;
    logic [POS_BITS-1:0] start;
    k = b[4:0] & NAL_TYPE_MASK;
    if (header_next) begin
      nal_kind = k;
      if (k == NAL_SPS) begin
        sps_beg = code_pos;
        sps_seen = 1'b1;
      end else if (k == NAL_PPS) begin
        pps_beg = code_pos;
        pps_seen = 1'b1;
      end else if (k == NAL_IDR && sps_seen && pps_seen) begin
        tracked_gop.found = 1'b1;
        tracked_gop.sps_start = OUT_W'(sps_beg);
        tracked_gop.sps_end = OUT_W'(sps_fin);
        tracked_gop.pps_start = OUT_W'(pps_beg);
        tracked_gop.pps_end = OUT_W'(pps_fin);
        tracked_gop.idr_start = OUT_W'(code_pos);
      end
      header_next = 1'b0;
    end
    if (b == BYTE_ZERO) begin
      if (zero_count != 2'd3) zero_count++;
    end else begin
      if (b == BYTE_ONE && zero_count >= 2'd2) begin
        start = scan_pos - POS_BITS'(zero_count);
        if (nal_kind == NAL_SPS) sps_fin = start;
        else if (nal_kind == NAL_PPS) pps_fin = start;
        code_pos = start;
        header_next = 1'b1;
      end
      zero_count = '0;
    end
    if (scan_pos != POS_LIMIT) scan_pos++;
    res = tracked_gop;
    if (last) clear_scanner();
    return last;
  endfunction

  task automatic note_mismatch(input string what, input logic [OUT_W-1:0] got,
                               input logic [OUT_W-1:0] want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit last, input bit typed,
                           input gop_t typed_gop);
    gop_t res;
    int gap;
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    sent_bytes++;
    if (scan_byte(b, last, res)) gop_q.push_back(typed ? typed_gop : res);
    if (idle_en && burst_left == 0) begin
      burst_left = $urandom_range(0, 24);
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic send_random_stream(input bit short_only);
    logic [7:0] s[$];
    logic [4:0] kind;
    int nals;
    int zeros;
    bit tidy;
    tidy = ($urandom_range(0, 3) != 0);
    if (short_only) begin
      repeat ($urandom_range(1, 3)) s.push_back(8'($urandom));
    end else begin
      if (!tidy) repeat ($urandom_range(0, 3)) s.push_back(8'($urandom));
      nals = tidy ? $urandom_range(3, 9) : $urandom_range(0, 6);
      for (int n = 0; n < nals; n++) begin
        if (tidy) begin
          case (n % 4)
            0: kind = NAL_SPS;
            1: kind = NAL_PPS;
            2: kind = NAL_IDR;
            default: kind = NAL_SLICE;
          endcase
        end else begin
          case ($urandom_range(0, 4))
            0: kind = NAL_SPS;
            1: kind = NAL_PPS;
            2: kind = NAL_IDR;
            3: kind = NAL_SLICE;
            default: kind = 5'($urandom);
          endcase
        end
        zeros = ($urandom_range(0, 2) == 0) ? 3 : 2;
        if ($urandom_range(0, 15) == 0) zeros = 5;
        repeat (zeros) s.push_back(BYTE_ZERO);
        s.push_back(BYTE_ONE);
        s.push_back({3'($urandom), kind});
        repeat ($urandom_range(0, 5))
          s.push_back(($urandom_range(0, 7) == 0) ? BYTE_ZERO : 8'($urandom));
      end
      if (!tidy) begin
        case ($urandom_range(0, 3))
          0: repeat ($urandom_range(1, 3)) s.push_back(BYTE_ZERO);
          1: begin
            repeat ($urandom_range(2, 3)) s.push_back(BYTE_ZERO);
            s.push_back(BYTE_ONE);
          end
          default: ;
        endcase
      end
      if (s.size() == 0) s.push_back(8'($urandom));
    end
    for (int i = 0; i < s.size(); i++) send_byte(s[i], i == s.size() - 1, 1'b0, blank_gop);
  endtask

  always @(posedge clk) begin : check_results
    gop_t want;
    logic [OUT_W-1:0] got_f[6];
    logic [OUT_W-1:0] want_f[6];
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (gop_q.size() == 0) begin
        note_mismatch("result with no transaction expected", out_idr_start, '0);
      end else begin
        want = gop_q.pop_front();
        got_f = '{OUT_W'(out_found), out_sps_start, out_sps_end, out_pps_start, out_pps_end,
                  out_idr_start};
        want_f = '{OUT_W'(want.found), want.sps_start, want.sps_end, want.pps_start,
                   want.pps_end, want.idr_start};
        for (int i = 0; i < 6; i++)
          if (got_f[i] !== want_f[i]) note_mismatch(field_name[i], got_f[i], want_f[i]);
      end
    end
  end

  initial begin : stall_gen
    int mode;
    int left;
    int hold_left;
    bit hold_done;
    bit s;
    out_stall = 1'b0;
    mode = 0;
    left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 120);
      end
      left--;
      case (mode)
        0: s = 1'b0;
        1: s = ($urandom_range(0, 3) == 0);
        2: s = $urandom_range(0, 1);
        default: s = ($urandom_range(0, 4) != 0);
      endcase
      if (hold_left > 0) begin
        s = 1'b1;
        hold_left--;
      end
      out_stall <= s;
    end
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int g;
    int n;
    int rand_start;
    int waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    blank_gop = '{default: '0};
    clear_scanner();
    field_name = '{"found", "sps_start", "sps_end", "pps_start", "pps_end", "idr_start"};
    // Rows are {last, byte}: a lone zero byte, a full SPS/PPS/IDR group with both code
    // lengths, and a stream with a zero header byte, an unqualified IDR and a cut code.
    dir_rows = '{
      9'h100,
      9'h000, 9'h000, 9'h001, {1'b0, 3'b011, NAL_SPS},
      9'h000, 9'h000, 9'h001, {1'b0, 3'b111, NAL_PPS},
      9'h000, 9'h000, 9'h000, 9'h001, {1'b0, 3'b001, NAL_IDR},
      9'h1ff,
      9'h000, 9'h000, 9'h001, 9'h000, 9'h000, 9'h001, {1'b0, 3'b000, NAL_IDR},
      9'h000, 9'h100
    };
    dir_gops[0] = '{default: '0};
    dir_gops[1] = '{1'b1, 40'd0, 40'd4, 40'd4, 40'd8, 40'd8};
    dir_gops[2] = '{default: '0};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    idle_en = 1'b1;
    g = 0;
    for (int i = 0; i < DIR_N; i++) begin
      send_byte(dir_rows[i][7:0], dir_rows[i][8], dir_rows[i][8], dir_gops[g]);
      if (dir_rows[i][8]) g++;
    end

    rand_start = sent_bytes;
    n = 0;
    while (sent_bytes - rand_start < RANDOM_BYTES) begin
      idle_en = ($urandom_range(0, 3) != 0);
      if (n == 12) begin
        // Many short streams while the receiver holds off fill the internal queue.
        idle_en = 1'b0;
        hold_req = 1'b1;
        repeat (24) send_random_stream(1'b1);
      end else begin
        send_random_stream(1'b0);
      end
      n++;
    end

    in_valid <= 1'b0;
    waited = 0;
    while (gop_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (gop_q.size() != 0)
      note_mismatch("transactions never delivered", '0, OUT_W'(gop_q.size()));
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/agl_pkg.sv
rtl/core/agl_front.sv
rtl/core/agl_fifo.sv
rtl/core/agl_back.sv
rtl/core/annexb_newest_gop_locator_unit.sv
rtl/core/agl_checker.sv
tb/tb_annexb_newest_gop_locator_unit.sv
